// File: src/rrss_pkg.sv
// Shared types and constants of the round-robin slice scheduler.
`default_nettype none

package rrss_pkg;

    localparam int REM_W      = 16;
    localparam int PRIO_W     = 2;
    localparam int IDX_W      = 4;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;
    localparam int NUM_SLICE_REGS = 4;
    localparam logic [REM_W-1:0] SLICE_RESET = 16'd10;

    // Item kinds carried in the input tuser
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SWAP  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_RUNNABLE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NO_TASK     = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_SLICE_PRIO0 = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SLICE_PRIO1 = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SLICE_PRIO2 = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SLICE_PRIO3 = 2'd3;

    // One task table entry as stored in memory
    typedef struct packed {
        logic [REM_W-1:0]  remaining;
        logic [PRIO_W-1:0] prio;
        logic              locked;
    } t_entry;

endpackage

`default_nettype wire

// File: src/rrss_slice_regs.sv
// Slice length registers per priority level with clamped lookup.
`default_nettype none

module rrss_slice_regs
    import rrss_pkg::*;
#(
    parameter int PRIORITY_LEVELS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic [PRIO_W-1:0]     i_prio,
    output logic      [REM_W-1:0]      o_slice
);

    localparam int PMAX_I = (PRIORITY_LEVELS - 1 > NUM_SLICE_REGS - 1) ?
                            NUM_SLICE_REGS - 1 : PRIORITY_LEVELS - 1;
    localparam logic [PRIO_W-1:0] PMAX = PRIO_W'(PMAX_I);

    logic [REM_W-1:0]  r_slice [NUM_SLICE_REGS];
    logic [PRIO_W-1:0] w_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLICE_REGS; i++) begin
                r_slice[i] <= SLICE_RESET;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_SLICE_PRIO0: r_slice[0] <= i_cfg_wdata;
                REG_SLICE_PRIO1: r_slice[1] <= i_cfg_wdata;
                REG_SLICE_PRIO2: r_slice[2] <= i_cfg_wdata;
                REG_SLICE_PRIO3: r_slice[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp priorities beyond the configured levels
    assign w_sel   = (i_prio > PMAX) ? PMAX : i_prio;
    assign o_slice = r_slice[w_sel];

endmodule

`default_nettype wire

// File: src/rrss_task_mem.sv
// Task table memory with one write port, one registered read port and valid bits.
`default_nettype none

module rrss_task_mem
    import rrss_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_entry             o_rd_data
);

    t_entry           mem [DEPTH];
    t_entry           r_rd_data;
    logic             r_rd_hit;
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    // An entry never written reads as all zero
    assign o_rd_data = r_rd_hit ? r_rd_data : '0;

endmodule

`default_nettype wire

// File: src/round_robin_slice_scheduler.sv
// Round-robin time-slice scheduler: top level with the scheduling sequencer.
//
// Input channel (i_s_*): one beat per item. tuser carries the kind (tick,
// forced swap, slot write); tdata carries the slot write fields. Output
// channel (o_m_*): one result beat per input beat, in order.
// Configuration: i_cfg_we writes slice register i_cfg_addr with i_cfg_wdata
// in the same cycle; write only while the block is idle.
// Task state lives in a one-port-read, one-port-write table memory with
// a registered read port, plus a present bit per slot and a present count.
// From accept to result register, a tick that counts down passes the
// dispatch, act and output states; a write or an item that finds no active
// task passes dispatch, final read, final data and output; a swap passes
// dispatch, act, one scan state per slot visited on the ring (1 to TASK_SLOTS,
// one memory read per slot) and output. One item is worked at a time.
// A new beat is accepted while a result still waits on the output; the
// sequencer holds its next result until the receiver takes the old one.
// Reset clears the table to empty (valid bits), no active task, slices 10.
`default_nettype none

module round_robin_slice_scheduler
    import rrss_pkg::*;
#(
    parameter int TASK_SLOTS      = 16,
    parameter int PRIORITY_LEVELS = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    // slot_index[3:0], slot_present[4], slot_priority[6:5], slot_locked[7],
    // slot_remaining[23:8], make_active[24], zero[31:25]
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  wire logic [KIND_W-1:0]     i_s_tuser,
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // active_slot[3:0], switched[4], remaining_ticks[20:5], status[22:21],
    // zero[23]
    output logic      [OUT_DATA_W-1:0] o_m_tdata
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int CW = $clog2(TASK_SLOTS + 1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(TASK_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_ACT,
        S_SCAN,
        S_FIN_RD,
        S_FIN_DATA,
        S_OUT
    } t_state;

    t_state r_state, n_state;

    // latched input beat
    logic [KIND_W-1:0] r_kind;
    logic [IDX_W-1:0]  r_idx;
    logic              r_pres;
    logic [PRIO_W-1:0] r_prio;
    logic              r_lock;
    logic [REM_W-1:0]  r_rem;
    logic              r_mk;

    // scheduler state
    logic [SW-1:0]         r_active, n_active;
    logic                  r_have, n_have;
    logic [TASK_SLOTS-1:0] r_present, n_present;
    logic [CW-1:0]         r_num_present, n_num_present;

    // scan and result
    logic [SW-1:0]       r_scan_slot, n_scan_slot;
    logic [CW-1:0]       r_scan_cnt, n_scan_cnt;
    logic [REM_W-1:0]    r_act_reload, n_act_reload;
    logic [REM_W-1:0]    r_res_rem, n_res_rem;
    logic                r_res_sw, n_res_sw;
    logic [STATUS_W-1:0] r_res_status, n_res_status;

    logic                  r_out_valid, n_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data, n_out_data;

    // memory ports
    logic          w_we, w_re;
    logic [SW-1:0] w_wa, w_ra;
    t_entry        w_wd, w_rd;
    logic [REM_W-1:0] w_slice;

    logic [8:0]    w_idx_ext, w_act_ext;
    logic          w_in_range;
    logic [SW-1:0] w_wr_slot, w_act_next, w_scan_next;
    logic          w_scan_pres;

    rrss_slice_regs #(
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_slice (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_prio      (w_rd.prio),
        .o_slice     (w_slice)
    );

    rrss_task_mem #(
        .DEPTH (TASK_SLOTS),
        .AW    (SW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_we),
        .i_wr_addr (w_wa),
        .i_wr_data (w_wd),
        .i_rd_en   (w_re),
        .i_rd_addr (w_ra),
        .o_rd_data (w_rd)
    );

    assign w_idx_ext   = {5'd0, r_idx};
    assign w_in_range  = w_idx_ext < 9'(TASK_SLOTS);
    assign w_wr_slot   = w_idx_ext[SW-1:0];
    assign w_act_ext   = 9'(r_active);
    assign w_act_next  = (r_active == LAST_SLOT) ? '0 : r_active + SW'(1);
    assign w_scan_next = (r_scan_slot == LAST_SLOT) ? '0 : r_scan_slot + SW'(1);
    assign w_scan_pres = r_present[r_scan_slot];

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        n_state       = r_state;
        n_active      = r_active;
        n_have        = r_have;
        n_present     = r_present;
        n_num_present = r_num_present;
        n_scan_slot   = r_scan_slot;
        n_scan_cnt    = r_scan_cnt;
        n_act_reload  = r_act_reload;
        n_res_rem     = r_res_rem;
        n_res_sw      = r_res_sw;
        n_res_status  = r_res_status;
        n_out_valid   = r_out_valid;
        n_out_data    = r_out_data;
        w_we = 1'b0;
        w_re = 1'b0;
        w_wa = r_active;
        w_ra = r_active;
        w_wd = '0;

        // drop the result once the receiver takes it
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_res_sw     = 1'b0;
                n_res_status = STATUS_OK;
                if (r_kind == KIND_WRITE) begin
                    if (w_in_range) begin
                        w_we = 1'b1;
                        w_wa = w_wr_slot;
                        w_wd = '{remaining: r_rem, prio: r_prio, locked: r_lock};
                        n_present[w_wr_slot] = r_pres;
                        if (r_pres && !r_present[w_wr_slot]) begin
                            n_num_present = r_num_present + CW'(1);
                        end else if (!r_pres && r_present[w_wr_slot]) begin
                            n_num_present = r_num_present - CW'(1);
                        end
                        if (r_mk) begin
                            n_res_sw = !r_have || (r_active != w_wr_slot);
                            n_active = w_wr_slot;
                            n_have   = 1'b1;
                        end
                    end
                    n_state = S_FIN_RD;
                end else if ((r_kind == KIND_TICK || r_kind == KIND_SWAP) &&
                             r_have && (r_num_present != '0)) begin
                    w_re    = 1'b1;
                    w_ra    = r_active;
                    n_state = S_ACT;
                end else begin
                    n_state = S_FIN_RD;
                end
            end
            S_ACT: begin
                w_we = 1'b1;
                w_wa = r_active;
                if (r_kind == KIND_TICK && w_rd.remaining != '0) begin
                    // count down the running task
                    w_wd = '{remaining: w_rd.remaining - REM_W'(1),
                             prio: w_rd.prio, locked: w_rd.locked};
                    n_res_rem = w_rd.remaining - REM_W'(1);
                    n_state   = S_OUT;
                end else begin
                    // reload the outgoing task and start the ring walk
                    w_wd = '{remaining: w_slice, prio: w_rd.prio,
                             locked: w_rd.locked};
                    n_act_reload = w_slice;
                    w_re        = 1'b1;
                    w_ra        = w_act_next;
                    n_scan_slot = w_act_next;
                    n_scan_cnt  = CW'(1);
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_scan_pres && !w_rd.locked) begin
                    n_res_sw  = (r_scan_slot != r_active);
                    n_active  = r_scan_slot;
                    n_res_rem = w_rd.remaining;
                    n_state   = S_OUT;
                end else begin
                    if (w_scan_pres) begin
                        // pass over a locked task, reloading it
                        w_we = 1'b1;
                        w_wa = r_scan_slot;
                        w_wd = '{remaining: w_slice, prio: w_rd.prio,
                                 locked: w_rd.locked};
                    end
                    if (r_scan_cnt == CW'(TASK_SLOTS)) begin
                        n_res_status = STATUS_NO_RUNNABLE;
                        n_res_rem    = r_act_reload;
                        n_state      = S_OUT;
                    end else begin
                        w_re        = 1'b1;
                        w_ra        = w_scan_next;
                        n_scan_slot = w_scan_next;
                        n_scan_cnt  = r_scan_cnt + CW'(1);
                    end
                end
            end
            S_FIN_RD: begin
                w_re    = 1'b1;
                w_ra    = r_active;
                n_state = S_FIN_DATA;
            end
            S_FIN_DATA: begin
                n_res_rem    = r_have ? w_rd.remaining : '0;
                n_res_status = (!r_have || r_num_present == '0) ?
                               STATUS_NO_TASK : STATUS_OK;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_res_status, r_res_rem, r_res_sw,
                                   w_act_ext[3:0]};
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_active      <= '0;
            r_have        <= 1'b0;
            r_present     <= '0;
            r_num_present <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_active      <= n_active;
            r_have        <= n_have;
            r_present     <= n_present;
            r_num_present <= n_num_present;
            r_out_valid   <= n_out_valid;
            r_scan_slot   <= n_scan_slot;
            r_scan_cnt    <= n_scan_cnt;
            r_act_reload  <= n_act_reload;
            r_res_rem     <= n_res_rem;
            r_res_sw      <= n_res_sw;
            r_res_status  <= n_res_status;
            r_out_data    <= n_out_data;
            if (r_state == S_IDLE && i_s_tvalid) begin
                r_kind <= i_s_tuser;
                r_idx  <= i_s_tdata[3:0];
                r_pres <= i_s_tdata[4];
                r_prio <= i_s_tdata[6:5];
                r_lock <= i_s_tdata[7];
                r_rem  <= i_s_tdata[23:8];
                r_mk   <= i_s_tdata[24];
            end
        end
    end

endmodule

`default_nettype wire

// File: bench/tb_round_robin_slice_scheduler.sv
// Self-checking testbench for the round-robin slice scheduler.
`default_nettype none

module tb_round_robin_slice_scheduler;
    import rrss_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TASK_SLOTS = 16;
    localparam int PHASE_ITEMS = 106;
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
    localparam logic [NUM_SLICE_REGS-1:0][CFG_ADDR_W-1:0] SLICE_REG_IDX =
        {REG_SLICE_PRIO3, REG_SLICE_PRIO2, REG_SLICE_PRIO1, REG_SLICE_PRIO0};

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
        logic              present;
        logic [PRIO_W-1:0] prio;
        logic              locked;
        logic [REM_W-1:0]  rem;
        logic              make_active;
    } t_sched_item;

    typedef struct packed {
        logic [IDX_W-1:0]    slot;
        logic                switched;
        logic [REM_W-1:0]    rem;
        logic [STATUS_W-1:0] status;
    } t_sched_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b1;
    logic [OUT_DATA_W-1:0] m_tdata;

    // Predictor state
    logic [REM_W-1:0]      slice_len [NUM_SLICE_REGS];
    logic [REM_W-1:0]      tbl_remaining [TASK_SLOTS];
    logic [PRIO_W-1:0]     tbl_prio [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] tbl_locked;
    logic [TASK_SLOTS-1:0] tbl_present;
    logic [IDX_W-1:0]      cur_slot;
    logic                  cur_valid;

    t_sched_result pending_results [$];
    t_sched_item   dir_items [$];
    bit            dir_typed [$];
    t_sched_result dir_results [$];

    int err_cnt = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int present_pct = 80;
    int lock_pct = 25;

    round_robin_slice_scheduler dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("** round_robin_slice_scheduler: FAILED **");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_cnt < 40)
            $display("MISMATCH at %0t: %s got %0d want %0d", $time, what, got, want);
        err_cnt++;
    endtask

    // Advance the scheduler state by one item and return its result.
    function automatic t_sched_result schedule_item(input t_sched_item it);
        t_sched_result res;
        logic found;
        int j;
        int s;
        res = '0;
        res.status = STATUS_OK;
        if (it.kind == KIND_WRITE) begin
            tbl_present[it.idx]   = it.present;
            tbl_prio[it.idx]      = it.prio;
            tbl_locked[it.idx]    = it.locked;
            tbl_remaining[it.idx] = it.rem;
            if (it.make_active) begin
                if (!cur_valid || cur_slot != it.idx)
                    res.switched = 1'b1;
                cur_slot  = it.idx;
                cur_valid = 1'b1;
            end
        end else if ((it.kind == KIND_TICK || it.kind == KIND_SWAP) && cur_valid &&
                     |tbl_present) begin
            if (it.kind == KIND_TICK && tbl_remaining[cur_slot] != '0) begin
                tbl_remaining[cur_slot] = tbl_remaining[cur_slot] - 1'b1;
            end else begin
                tbl_remaining[cur_slot] = slice_len[tbl_prio[cur_slot]];
                found = 1'b0;
                for (j = 1; j <= TASK_SLOTS && !found; j++) begin
                    s = (int'(cur_slot) + j) % TASK_SLOTS;
                    if (tbl_present[s]) begin
                        if (tbl_locked[s]) begin
                            // pass over a locked task with a fresh slice
                            tbl_remaining[s] = slice_len[tbl_prio[s]];
                        end else begin
                            found = 1'b1;
                            if (s != int'(cur_slot))
                                res.switched = 1'b1;
                            cur_slot = s[IDX_W-1:0];
                        end
                    end
                end
                if (!found)
                    res.status = STATUS_NO_RUNNABLE;
            end
        end
        if (res.status == STATUS_OK && (!cur_valid || !(|tbl_present)))
            res.status = STATUS_NO_TASK;
        res.slot = cur_slot;
        res.rem  = cur_valid ? tbl_remaining[cur_slot] : '0;
        return res;
    endfunction

    task automatic dir_row(input logic [KIND_W-1:0] kind, input int idx, input bit pres,
                           input int prio, input bit lock, input int rem, input bit mk,
                           input bit typed, input int slot, input bit sw, input int rrem,
                           input logic [STATUS_W-1:0] st);
        t_sched_item it;
        t_sched_result r;
        it = {kind, idx[IDX_W-1:0], pres, prio[PRIO_W-1:0], lock, rem[REM_W-1:0], mk};
        r  = {slot[IDX_W-1:0], sw, rrem[REM_W-1:0], st};
        dir_items.push_back(it);
        dir_typed.push_back(typed);
        dir_results.push_back(r);
    endtask

    function automatic t_sched_item rand_item();
        t_sched_item it;
        int r;
        int pick;
        it = t_sched_item'($urandom);
        r  = $urandom_range(99);
        if (r < 3) begin
            it.kind = KIND_NONE;
        end else if (r < 24) begin
            it.kind    = KIND_WRITE;
            it.present = ($urandom_range(99) < present_pct);
            it.locked  = ($urandom_range(99) < lock_pct);
            it.make_active = ($urandom_range(99) < 25);
            pick = $urandom_range(9);
            if (pick == 0)
                it.rem = '1;
            else if (pick == 1)
                it.rem = REM_W'($urandom);
            else
                it.rem = REM_W'($urandom_range(4));
        end else if (r < 42) begin
            it.kind = KIND_SWAP;
        end else begin
            it.kind = KIND_TICK;
        end
        return it;
    endfunction

    // Offer one beat, hold it until taken, and queue its result.
    task automatic send_item(input t_sched_item it, input bit typed,
                             input t_sched_result typed_res);
        t_sched_result pred;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it.make_active, it.rem, it.locked, it.prio, it.present, it.idx};
        s_tuser  <= it.kind;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        pred = schedule_item(it);
        pending_results.push_back(typed ? typed_res : pred);
    endtask

    always @(posedge i_clk) begin
        t_sched_result got;
        t_sched_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[3:0], m_tdata[4], m_tdata[20:5], m_tdata[22:21]};
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, active_slot", got.slot, -1);
            end else begin
                want = pending_results.pop_front();
                if (got.slot != want.slot)
                    report_mismatch("active_slot", got.slot, want.slot);
                if (got.switched != want.switched)
                    report_mismatch("switched", got.switched, want.switched);
                if (got.rem != want.rem)
                    report_mismatch("remaining_ticks", got.rem, want.rem);
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        logic [REM_W-1:0] phase_slices [NUM_SLICE_REGS];
        int ph;
        int n;
        int r;

        for (r = 0; r < NUM_SLICE_REGS; r++)
            slice_len[r] = SLICE_RESET;
        for (r = 0; r < TASK_SLOTS; r++) begin
            tbl_remaining[r] = '0;
            tbl_prio[r]      = '0;
        end
        tbl_locked  = '0;
        tbl_present = '0;
        cur_slot    = '0;
        cur_valid   = 1'b0;

        // empty table: nothing runs
        dir_row(KIND_TICK,  0, 0, 0, 0, 0, 0,         1, 0, 0, 0, STATUS_NO_TASK);
        dir_row(KIND_SWAP,  0, 0, 0, 0, 0, 0,         1, 0, 0, 0, STATUS_NO_TASK);
        dir_row(KIND_NONE, 15, 1, 3, 1, 65535, 1,     1, 0, 0, 0, STATUS_NO_TASK);
        // present task but no active one yet
        dir_row(KIND_WRITE, 0, 1, 0, 0, 0, 0,         1, 0, 0, 0, STATUS_NO_TASK);
        dir_row(KIND_WRITE, 15, 1, 3, 0, 65535, 1,    1, 15, 1, 65535, STATUS_OK);
        dir_row(KIND_TICK,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        // wrap from the top slot, then expire a zero count
        dir_row(KIND_SWAP,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_TICK,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_WRITE, 5, 1, 2, 1, 7, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_SWAP,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_SWAP,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        // lock the whole ring
        dir_row(KIND_WRITE, 0, 1, 0, 1, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_WRITE, 15, 1, 3, 1, 3, 0,        0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_SWAP,  0, 0, 0, 0, 0, 0,         1, 15, 0, 10, STATUS_NO_RUNNABLE);
        // active slot that is not in the ring
        dir_row(KIND_WRITE, 7, 0, 1, 0, 1, 1,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_TICK,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_TICK,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_WRITE, 9, 1, 1, 0, 2, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_SWAP,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        // make the already active slot active again
        dir_row(KIND_WRITE, 9, 0, 1, 0, 65535, 1,     0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_SWAP,  0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        // empty the ring while a task stays active
        dir_row(KIND_WRITE, 0, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_WRITE, 5, 0, 0, 0, 0, 0,         0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_WRITE, 15, 0, 0, 0, 0, 0,        0, 0, 0, 0, STATUS_OK);
        dir_row(KIND_TICK,  0, 0, 0, 0, 0, 0,         1, 9, 0, 10, STATUS_NO_TASK);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < dir_items.size(); n++)
            send_item(dir_items[n], dir_typed[n], dir_results[n]);
        s_tvalid <= 1'b0;

        for (ph = 0; ph < 4; ph++) begin
            // drain before touching the slice registers
            while (pending_results.size() != 0)
                @(posedge i_clk);
            case (ph)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                    present_pct = 80;   lock_pct = 25;
                    for (r = 0; r < NUM_SLICE_REGS; r++)
                        phase_slices[r] = '0;
                end
                1: begin
                    send_idle_pct = 59; recv_stall_pct = 0;
                    present_pct = 90;   lock_pct = 10;
                    for (r = 0; r < NUM_SLICE_REGS; r++)
                        phase_slices[r] = '1;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 59;
                    present_pct = 60;   lock_pct = 70;
                    for (r = 0; r < NUM_SLICE_REGS; r++)
                        phase_slices[r] = REM_W'($urandom_range(6, 1));
                end
                default: begin
                    send_idle_pct = 34; recv_stall_pct = 34;
                    present_pct = 30;   lock_pct = 40;
                    phase_slices[0] = '0;
                    phase_slices[1] = '1;
                    phase_slices[2] = 16'd1;
                    phase_slices[3] = 16'd3;
                end
            endcase
            for (r = 0; r < NUM_SLICE_REGS; r++) begin
                cfg_we    <= 1'b1;
                cfg_addr  <= SLICE_REG_IDX[r];
                cfg_wdata <= phase_slices[r];
                slice_len[SLICE_REG_IDX[r]] = phase_slices[r];
                @(posedge i_clk);
            end
            cfg_we <= 1'b0;
            for (n = 0; n < PHASE_ITEMS; n++)
                send_item(rand_item(), 1'b0, '0);
            s_tvalid <= 1'b0;
        end

        while (pending_results.size() != 0)
            @(posedge i_clk);
        // watch for stray results after the last one
        repeat (40) @(posedge i_clk);
        if (err_cnt == 0)
            $display("** round_robin_slice_scheduler: PASSED **");
        else
            $display("** round_robin_slice_scheduler: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire
